/* hdl/upst_pkg.sv */
// Shared types, codes and defaults for the USB power source tracker.
// No dependencies; every other file of the block imports this package.
package upst_pkg;

  localparam int COUNT_BITS_DEF   = 13;
  localparam int CURRENT_BITS_DEF = 10;

  localparam int CMD_W       = 3;
  localparam int CUR_FIELD_W = 10;
  localparam int CFG_CNT_W   = 13;
  localparam int CFG_CUR_W   = 10;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_VBUS    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GRANT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_STARTED = 2'd3;

  localparam logic [1:0] SRC_NONE    = 2'd0;
  localparam logic [1:0] SRC_BUS     = 2'd1;
  localparam logic [1:0] SRC_CHARGER = 2'd2;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_PULLUP = 2'd1;
  localparam logic [1:0] PH_LINES  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PULLUP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGER_MA   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONCONF_MA   = 2'd3;

  localparam logic [CFG_CNT_W-1:0] PULLUP_LIMIT_RST = 13'd100;
  localparam logic [CFG_CNT_W-1:0] LINE_LIMIT_RST   = 13'd5000;
  localparam logic [CFG_CUR_W-1:0] CHARGER_MA_RST   = 10'd1000;
  localparam logic [CFG_CUR_W-1:0] NONCONF_MA_RST   = 10'd500;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic                   vbus_level;
    logic [CUR_FIELD_W-1:0] requested_ma;
    logic                   pullup_seen;
    logic                   dplus;
    logic                   dminus;
  } upst_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   power_changed;
    logic                   host_changed;
    logic                   host_attached;
    logic [1:0]             power_source;
    logic [CUR_FIELD_W-1:0] draw_ma;
    logic                   disconnect_request;
  } upst_result_t;

  typedef struct packed {
    logic [CFG_CNT_W-1:0] pullup_limit;
    logic [CFG_CNT_W-1:0] line_limit;
    logic [CFG_CUR_W-1:0] charger_ma;
    logic [CFG_CUR_W-1:0] nonconforming_ma;
  } upst_cfg_t;

endpackage

/* hdl/upst_if.sv */
// Valid/ready channel interfaces for command transactions and result transactions.
// Depends on upst_pkg for the field widths.
interface upst_in_if import upst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic                   vbus_level;
  logic [CUR_FIELD_W-1:0] requested_ma;
  logic                   pullup_seen;
  logic                   dplus;
  logic                   dminus;

  modport source (output valid, command, vbus_level, requested_ma, pullup_seen, dplus,
                  dminus, input ready);
  modport sink   (input valid, command, vbus_level, requested_ma, pullup_seen, dplus,
                  dminus, output ready);
endinterface

interface upst_out_if import upst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic                   power_changed;
  logic                   host_changed;
  logic                   host_attached;
  logic [1:0]             power_source;
  logic [CUR_FIELD_W-1:0] draw_ma;
  logic                   disconnect_request;

  modport source (output valid, status, power_changed, host_changed, host_attached,
                  power_source, draw_ma, disconnect_request, input ready);
  modport sink   (input valid, status, power_changed, host_changed, host_attached,
                  power_source, draw_ma, disconnect_request, output ready);
endinterface

/* hdl/usb_power_source_tracker_top.sv */
// Top level of the USB power source tracker: channels, config registers, pipeline.
// Depends on upst_pkg, upst_if and upst_engine.
//
// Each command transaction yields exactly one result transaction. A command is
// captured in an input register, decoded against the tracker state, and its
// result lands in an output register; with the result side ready the block
// takes one command per clock, and the result is valid once it is in that register.
// Throughput is set only by the output register draining. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and must be made while no
// command is in flight.
module usb_power_source_tracker_top import upst_pkg::*; #(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int CURRENT_BITS = CURRENT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  upst_in_if.sink               in_ch,
  upst_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  upst_cfg_t    cfg_r;
  logic         s1_valid_r, s1_valid_nxt;
  upst_item_t   s1_item_r;
  logic         out_valid_r, out_valid_nxt;
  upst_result_t out_res_r;
  upst_result_t res;
  logic         advance;
  logic         in_take;

  assign advance       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || advance;
  assign in_take       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  upst_engine #(
    .COUNT_BITS   (COUNT_BITS),
    .CURRENT_BITS (CURRENT_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pullup_limit     <= PULLUP_LIMIT_RST;
      cfg_r.line_limit       <= LINE_LIMIT_RST;
      cfg_r.charger_ma       <= CHARGER_MA_RST;
      cfg_r.nonconforming_ma <= NONCONF_MA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULLUP_LIMIT: cfg_r.pullup_limit     <= cfg_data[CFG_CNT_W-1:0];
        REG_LINE_LIMIT:   cfg_r.line_limit       <= cfg_data[CFG_CNT_W-1:0];
        REG_CHARGER_MA:   cfg_r.charger_ma       <= cfg_data[CFG_CUR_W-1:0];
        REG_NONCONF_MA:   cfg_r.nonconforming_ma <= cfg_data[CFG_CUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.command      <= in_ch.command;
      s1_item_r.vbus_level   <= in_ch.vbus_level;
      s1_item_r.requested_ma <= in_ch.requested_ma;
      s1_item_r.pullup_seen  <= in_ch.pullup_seen;
      s1_item_r.dplus        <= in_ch.dplus;
      s1_item_r.dminus       <= in_ch.dminus;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_res_r.status;
  assign out_ch.power_changed      = out_res_r.power_changed;
  assign out_ch.host_changed       = out_res_r.host_changed;
  assign out_ch.host_attached      = out_res_r.host_attached;
  assign out_ch.power_source       = out_res_r.power_source;
  assign out_ch.draw_ma            = out_res_r.draw_ma;
  assign out_ch.disconnect_request = out_res_r.disconnect_request;

endmodule

/* hdl/upst_engine.sv */
// Tracker state and the single-pass command decode that updates it.
// Depends on upst_pkg; state advances on fire, result is combinational.
module upst_engine import upst_pkg::*; #(
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  parameter int CURRENT_BITS = CURRENT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  upst_item_t   item,
  input  upst_cfg_t    cfg,
  output upst_result_t res
);

  localparam int CW = CURRENT_BITS;
  localparam int KW = COUNT_BITS;

  logic          enabled_r, enabled_nxt;
  logic          vbus_r, vbus_nxt;
  logic [CW-1:0] allowed_r, allowed_nxt;
  logic [1:0]    src_r, src_nxt;
  logic          host_r, host_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [KW-1:0] elapsed_r, elapsed_nxt;
  logic [CW-1:0] saved_r, saved_nxt;

  logic [CW+CUR_FIELD_W-1:0] req_ext;
  logic [CW-1:0]             req_c;
  logic [CW+CFG_CUR_W-1:0]   fin_ext;
  logic [CFG_CUR_W-1:0]      fin_raw;
  logic [CW-1:0]             fin_c;
  logic [CW+CUR_FIELD_W-1:0] out_ext;
  logic                      ended;
  logic                      do_vbus;

  function automatic logic reached(input logic [KW-1:0] el, input logic [CFG_CNT_W-1:0] lim);
    logic [KW+CFG_CNT_W-1:0] a;
    logic [KW+CFG_CNT_W-1:0] b;
    a = {{CFG_CNT_W{1'b0}}, el};
    b = {{KW{1'b0}}, lim};
    return (a >= b) || (el == {KW{1'b1}});
  endfunction

  assign req_ext = {{CW{1'b0}}, item.requested_ma};
  assign req_c   = req_ext[CW-1:0];
  assign fin_ext = {{CW{1'b0}}, fin_raw};
  assign fin_c   = fin_ext[CW-1:0];

  always_comb begin
    enabled_nxt = enabled_r;
    vbus_nxt    = vbus_r;
    allowed_nxt = allowed_r;
    src_nxt     = src_r;
    host_nxt    = host_r;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    saved_nxt   = saved_r;
    fin_raw     = '0;
    ended       = 1'b0;
    do_vbus     = 1'b0;
    res         = '0;
    res.status  = ST_IGNORED;

    if (phase_r != PH_IDLE) begin
      res.status = ST_BUSY;
      if (item.command == CMD_TICK) begin
        if (phase_r == PH_PULLUP) begin
          if (item.pullup_seen) begin
            phase_nxt   = PH_LINES;
            elapsed_nxt = '0;
          end else if (reached(elapsed_r, cfg.pullup_limit)) begin
            ended = 1'b1;
          end else if (elapsed_r != {KW{1'b1}}) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
        end
        if (!ended && phase_nxt == PH_LINES) begin
          if (item.dplus && item.dminus) begin
            fin_raw = cfg.charger_ma;
            ended   = 1'b1;
          end else if (!item.dplus && !item.dminus) begin
            ended = 1'b1;
          end else if (reached(elapsed_nxt, cfg.line_limit)) begin
            fin_raw = item.dplus ? cfg.nonconforming_ma : '0;
            ended   = 1'b1;
          end else if (elapsed_nxt != {KW{1'b1}}) begin
            elapsed_nxt = elapsed_nxt + 1'b1;
          end
        end
        if (ended) begin
          if (fin_c != '0) begin
            allowed_nxt = fin_c;
            src_nxt     = SRC_CHARGER;
          end
          phase_nxt           = PH_IDLE;
          elapsed_nxt         = '0;
          res.status          = ST_DONE;
          res.power_changed   = (saved_r != allowed_nxt);
        end
      end
    end else begin
      case (item.command)
        CMD_ENABLE: begin
          if (!enabled_r) begin
            enabled_nxt = 1'b1;
            do_vbus     = 1'b1;
          end
        end
        CMD_DISABLE: begin
          if (enabled_r) begin
            vbus_nxt          = 1'b0;
            allowed_nxt       = '0;
            src_nxt           = SRC_NONE;
            enabled_nxt       = 1'b0;
            res.power_changed = (allowed_r != '0);
            res.status        = ST_DONE;
          end
        end
        CMD_VBUS: begin
          do_vbus = enabled_r;
        end
        CMD_GRANT: begin
          if (enabled_r && vbus_r && !(src_r != SRC_BUS && req_c == '0)) begin
            allowed_nxt = req_c;
            src_nxt     = (req_c != '0) ? SRC_BUS : SRC_NONE;
            if ((src_r == SRC_BUS) != (src_nxt == SRC_BUS)) begin
              host_nxt = (src_nxt == SRC_BUS);
            end
            res.host_changed  = (host_r != host_nxt);
            res.power_changed = (allowed_r != allowed_nxt);
            res.status        = ST_DONE;
          end
        end
        CMD_SUSPEND: begin
          if (enabled_r) begin
            if (src_r == SRC_BUS) begin
              allowed_nxt = '0;
              src_nxt     = SRC_NONE;
            end
            res.power_changed = (allowed_r != allowed_nxt);
            res.status        = ST_DONE;
          end
        end
        default: begin
        end
      endcase

      if (do_vbus) begin
        vbus_nxt    = item.vbus_level;
        allowed_nxt = '0;
        src_nxt     = SRC_NONE;
        if (!item.vbus_level && host_r) begin
          host_nxt         = 1'b0;
          res.host_changed = 1'b1;
        end
        res.disconnect_request = vbus_r && !item.vbus_level;
        if (!vbus_r && item.vbus_level) begin
          phase_nxt   = PH_PULLUP;
          elapsed_nxt = '0;
          saved_nxt   = allowed_r;
          res.status  = ST_STARTED;
        end else begin
          res.power_changed = (allowed_r != '0);
          res.status        = ST_DONE;
        end
      end
    end

    out_ext           = {{CUR_FIELD_W{1'b0}}, allowed_nxt};
    res.draw_ma       = out_ext[CUR_FIELD_W-1:0];
    res.host_attached = host_nxt;
    res.power_source  = src_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      vbus_r    <= 1'b0;
      allowed_r <= '0;
      src_r     <= SRC_NONE;
      host_r    <= 1'b0;
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      saved_r   <= '0;
    end else if (fire) begin
      enabled_r <= enabled_nxt;
      vbus_r    <= vbus_nxt;
      allowed_r <= allowed_nxt;
      src_r     <= src_nxt;
      host_r    <= host_nxt;
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      saved_r   <= saved_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_detect_no_power: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (allowed_r == '0 && src_r == SRC_NONE))
    else $error("power granted while detection runs");

  a_source_matches_current: assert property (@(posedge clk) disable iff (!rst_n)
    (src_r == SRC_NONE) == (allowed_r == '0))
    else $error("source and allowed current disagree");

  a_start_arms_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.status == ST_STARTED) |=> (phase_r == PH_PULLUP && elapsed_r == '0))
    else $error("detection start did not arm pull-up phase");

  a_idle_tick_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_IDLE && item.command == CMD_TICK) |-> (res.status == ST_IGNORED))
    else $error("tick outside detection not ignored");
`endif

endmodule
